FILE: design/utf8sd_pkg.sv
// Package for the UTF-8 stream decoder.
// Holds lead byte classification, payload masks and status codes.
// No dependencies.
package utf8sd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned RemW  = 2;

  typedef logic [2:0] seq_len_t;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam logic [ByteW-1:0] LEAD1_MASK  = 8'h80;
  localparam logic [ByteW-1:0] LEAD1_VAL   = 8'h00;
  localparam logic [ByteW-1:0] LEAD2_MASK  = 8'hE0;
  localparam logic [ByteW-1:0] LEAD2_VAL   = 8'hC0;
  localparam logic [ByteW-1:0] LEAD3_MASK  = 8'hF0;
  localparam logic [ByteW-1:0] LEAD3_VAL   = 8'hE0;
  localparam logic [ByteW-1:0] LEAD4_MASK  = 8'hF8;
  localparam logic [ByteW-1:0] LEAD4_VAL   = 8'hF0;
  localparam logic [ByteW-1:0] PAY2_MASK   = 8'h1F;
  localparam logic [ByteW-1:0] PAY3_MASK   = 8'h0F;
  localparam logic [ByteW-1:0] PAY4_MASK   = 8'h07;

  // Sequence length from a lead byte; zero marks an invalid lead.
  function automatic seq_len_t lead_length(input logic [ByteW-1:0] b);
    seq_len_t len;
    priority if ((b & LEAD1_MASK) == LEAD1_VAL) len = 3'd1;
    else if ((b & LEAD2_MASK) == LEAD2_VAL) len = 3'd2;
    else if ((b & LEAD3_MASK) == LEAD3_VAL) len = 3'd3;
    else if ((b & LEAD4_MASK) == LEAD4_VAL) len = 3'd4;
    else len = 3'd0;
    return len;
  endfunction

  // Payload bits of a multi-byte lead byte.
  function automatic logic [ByteW-1:0] lead_payload(input logic [ByteW-1:0] b,
                                                    input seq_len_t len);
    logic [ByteW-1:0] p;
    unique case (len)
      3'd2:    p = b & PAY2_MASK;
      3'd3:    p = b & PAY3_MASK;
      default: p = b & PAY4_MASK;
    endcase
    return p;
  endfunction

endpackage

FILE: design/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder.
// Input skid register, one decode step and an output register.
// Depends on utf8sd_pkg.
//
// Bytes enter on the input channel (byte_in_i, string_end_i) one per beat;
// decoded code points leave on the output channel (code_point_o, status_o,
// final_res_o). Both channels use valid and stall: a beat moves at a clock
// edge where valid is high and stall is low.
// A beat is registered at acceptance and decoded from the decode register;
// its result is then registered in the output register, which drives out_valid_o.
// One byte is taken every cycle when the output is not stalled. Bytes that
// open or continue a sequence, and bytes dropped after an invalid lead,
// give no result. An invalid lead or a string that ends inside a sequence
// gives one error beat with final_res_o set.
// When the receiver stalls, the pending result holds in the output register
// and the next byte waits in the decode register; one more byte is then
// caught in a skid register, after which in_stall_o rises. in_stall_o comes
// straight from a register.
// Reset clears the decoder state and empties all registers.
module utf8_stream_decoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [utf8sd_pkg::ByteW-1:0]   byte_in_i,
  input  logic                           string_end_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [utf8sd_pkg::CpW-1:0]     code_point_o,
  output logic                           status_o,
  output logic                           final_res_o
);

  logic                         in_acc;
  logic                         sk_v_q, sk_v_d;
  logic [utf8sd_pkg::ByteW-1:0] sk_byte_q;
  logic                         sk_end_q;
  logic                         s1_v_q, s1_v_d;
  logic [utf8sd_pkg::ByteW-1:0] s1_byte_q;
  logic                         s1_end_q;
  logic                         s1_free, s1_adv;

  logic [utf8sd_pkg::RemW-1:0]  rem_q, rem_d;
  logic [utf8sd_pkg::CpW-1:0]   gath_q, gath_d;
  logic                         skip_q, skip_d;

  logic                         res_has;
  logic [utf8sd_pkg::CpW-1:0]   res_cp;
  logic                         res_status, res_final;
  utf8sd_pkg::seq_len_t         len;
  logic [utf8sd_pkg::CpW-1:0]   shifted;
  logic [utf8sd_pkg::RemW-1:0]  rem_dec;

  logic                         out_v_q, out_v_d;
  logic [utf8sd_pkg::CpW-1:0]   cp_q;
  logic                         status_q, final_q;

  assign in_stall_o = sk_v_q;
  assign in_acc     = in_valid_i && !sk_v_q;

  assign len     = utf8sd_pkg::lead_length(s1_byte_q);
  assign shifted = {gath_q[utf8sd_pkg::CpW-7:0], s1_byte_q[5:0]};
  assign rem_dec = rem_q - 2'd1;

  always_comb begin
    res_has    = 1'b0;
    res_cp     = '0;
    res_status = utf8sd_pkg::STATUS_OK;
    res_final  = s1_end_q;
    rem_d      = rem_q;
    gath_d     = gath_q;
    skip_d     = skip_q;
    if (skip_q) begin
      skip_d = !s1_end_q;
    end else if (rem_q == '0) begin
      if (len == 3'd0) begin
        res_has    = 1'b1;
        res_status = utf8sd_pkg::STATUS_ERR;
        res_final  = 1'b1;
        skip_d     = !s1_end_q;
      end else if (len == 3'd1) begin
        res_has = 1'b1;
        res_cp  = {{(utf8sd_pkg::CpW-utf8sd_pkg::ByteW){1'b0}}, s1_byte_q};
      end else if (s1_end_q) begin
        res_has    = 1'b1;
        res_status = utf8sd_pkg::STATUS_ERR;
        res_final  = 1'b1;
        gath_d     = '0;
      end else begin
        gath_d = {{(utf8sd_pkg::CpW-utf8sd_pkg::ByteW){1'b0}},
                  utf8sd_pkg::lead_payload(s1_byte_q, len)};
        rem_d  = utf8sd_pkg::RemW'(len - 3'd1);
      end
    end else begin
      gath_d = shifted;
      rem_d  = rem_dec;
      if (rem_dec == '0) begin
        res_has = 1'b1;
        res_cp  = shifted;
        gath_d  = '0;
      end else if (s1_end_q) begin
        res_has    = 1'b1;
        res_status = utf8sd_pkg::STATUS_ERR;
        res_final  = 1'b1;
        rem_d      = '0;
        gath_d     = '0;
      end
    end
  end

  assign s1_adv  = s1_v_q && (!res_has || !out_v_q || !out_stall_i);
  assign s1_free = !s1_v_q || s1_adv;

  always_comb begin
    s1_v_d = s1_v_q;
    sk_v_d = sk_v_q;
    if (s1_free) begin
      s1_v_d = sk_v_q || in_acc;
      sk_v_d = 1'b0;
    end else if (in_acc) begin
      sk_v_d = 1'b1;
    end
    out_v_d = (out_v_q && out_stall_i) || (s1_adv && res_has);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sk_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      rem_q   <= '0;
      gath_q  <= '0;
      skip_q  <= 1'b0;
    end else begin
      sk_v_q  <= sk_v_d;
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
      if (s1_adv) begin
        rem_q  <= rem_d;
        gath_q <= gath_d;
        skip_q <= skip_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !s1_free) begin
      sk_byte_q <= byte_in_i;
      sk_end_q  <= string_end_i;
    end
    if (s1_free) begin
      if (sk_v_q) begin
        s1_byte_q <= sk_byte_q;
        s1_end_q  <= sk_end_q;
      end else begin
        s1_byte_q <= byte_in_i;
        s1_end_q  <= string_end_i;
      end
    end
    if (s1_adv && res_has) begin
      cp_q     <= res_cp;
      status_q <= res_status;
      final_q  <= res_final;
    end
  end

  assign out_valid_o  = out_v_q;
  assign code_point_o = cp_q;
  assign status_o     = status_q;
  assign final_res_o  = final_q;

endmodule

FILE: tb/utf8_decode_checker.sv
// Checker for the UTF-8 stream decoder: watches both channels, predicts the decoded
// results and compares each accepted output beat against the oldest expectation.
// Depends on utf8sd_pkg.
module utf8_decode_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic [utf8sd_pkg::ByteW-1:0] byte_i,
  input  logic                         string_end_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [utf8sd_pkg::CpW-1:0]   code_point_i,
  input  logic                         status_i,
  input  logic                         final_res_i,
  output int                           errors_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [utf8sd_pkg::ByteW-1:0] ContMask = 8'h3F;
  localparam logic [utf8sd_pkg::ByteW-1:0] Lead2Pay = 8'h1F;
  localparam logic [utf8sd_pkg::ByteW-1:0] Lead3Pay = 8'h0F;
  localparam logic [utf8sd_pkg::ByteW-1:0] Lead4Pay = 8'h07;

  typedef struct packed {
    logic [utf8sd_pkg::CpW-1:0] cp;
    logic                       status;
    logic                       fin;
  } cp_result_t;

  cp_result_t                  cp_expected_q[$];
  logic [utf8sd_pkg::RemW-1:0] bytes_left;
  logic [utf8sd_pkg::CpW-1:0]  cp_accum;
  logic                        dropping;
  int                          mismatch_count;

  assign errors_o = mismatch_count;

  task automatic report_mismatch(input string what, input int unsigned exp_val,
                                 input int unsigned got_val);
    $display("%0t ns: mismatch in %s: expected 'h%0h, got 'h%0h", $realtime, what,
             exp_val, got_val);
    mismatch_count++;
  endtask

  function automatic int unsigned seq_length(input logic [utf8sd_pkg::ByteW-1:0] b);
    casez (b)
      8'b0???????: return 1;
      8'b110?????: return 2;
      8'b1110????: return 3;
      8'b11110???: return 4;
      default:     return 0;
    endcase
  endfunction

  task automatic push_result(input logic [utf8sd_pkg::CpW-1:0] cp, input logic st,
                             input logic fin);
    cp_result_t r;
    r.cp = cp;
    r.status = st;
    r.fin = fin;
    cp_expected_q.push_back(r);
  endtask

  task automatic decode_utf8_byte(input logic [utf8sd_pkg::ByteW-1:0] b, input logic last);
    int unsigned len;
    if (dropping) begin
      if (last) dropping = 1'b0;
    end else if (bytes_left == '0) begin
      len = seq_length(b);
      if (len == 0) begin
        dropping = !last;
        push_result('0, utf8sd_pkg::STATUS_ERR, 1'b1);
      end else if (len == 1) begin
        push_result(utf8sd_pkg::CpW'(b), utf8sd_pkg::STATUS_OK, last);
      end else if (last) begin
        cp_accum = '0;
        push_result('0, utf8sd_pkg::STATUS_ERR, 1'b1);
      end else begin
        case (len)
          2:       cp_accum = utf8sd_pkg::CpW'(b & Lead2Pay);
          3:       cp_accum = utf8sd_pkg::CpW'(b & Lead3Pay);
          default: cp_accum = utf8sd_pkg::CpW'(b & Lead4Pay);
        endcase
        bytes_left = utf8sd_pkg::RemW'(len - 1);
      end
    end else begin
      cp_accum = {cp_accum[utf8sd_pkg::CpW-7:0], 6'(b & ContMask)};
      bytes_left = bytes_left - 1'b1;
      if (bytes_left == '0) begin
        push_result(cp_accum, utf8sd_pkg::STATUS_OK, last);
        cp_accum = '0;
      end else if (last) begin
        bytes_left = '0;
        cp_accum = '0;
        push_result('0, utf8sd_pkg::STATUS_ERR, 1'b1);
      end
    end
  endtask

  task automatic check_result();
    cp_result_t want;
    if (cp_expected_q.size() == 0) begin
      report_mismatch("unexpected result beat, code_point", 0, code_point_i);
    end else begin
      want = cp_expected_q.pop_front();
      if (code_point_i !== want.cp) report_mismatch("code_point", want.cp, code_point_i);
      if (status_i !== want.status) report_mismatch("status", want.status, status_i);
      if (final_res_i !== want.fin) report_mismatch("final_res", want.fin, final_res_i);
    end
  endtask

  initial mismatch_count = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left = '0;
      cp_accum = '0;
      dropping = 1'b0;
      cp_expected_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) decode_utf8_byte(byte_i, string_end_i);
    end
    pending_o = cp_expected_q.size();
  end

endmodule

FILE: tb/tb_utf8_stream_decoder.sv
// Testbench top for the UTF-8 stream decoder: drives directed and random byte
// strings with random idling and stalls, and gives the verdict.
// Depends on utf8sd_pkg, utf8_stream_decoder and utf8_decode_checker.
module tb_utf8_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldCycles    = 80;
  localparam int unsigned PhaseItems    = 550;

  logic                         clk_i;
  logic                         rst_ni = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [utf8sd_pkg::ByteW-1:0] byte_in = '0;
  logic                         string_end = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [utf8sd_pkg::CpW-1:0]   code_point;
  logic                         status;
  logic                         final_res;
  int                           error_count;
  int                           pending;

  int unsigned tx_idle_pct = 11;
  int unsigned rx_idle_pct = 51;
  int unsigned items_sent = 0;
  bit          hold_request = 1'b0;
  bit          hold_served = 1'b0;

  utf8_stream_decoder DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .byte_in_i    (byte_in),
    .string_end_i (string_end),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .code_point_o (code_point),
    .status_o     (status),
    .final_res_o  (final_res)
  );

  utf8_decode_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .byte_i       (byte_in),
    .string_end_i (string_end),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .code_point_i (code_point),
    .status_i     (status),
    .final_res_i  (final_res),
    .errors_o     (error_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic send_byte(input logic [utf8sd_pkg::ByteW-1:0] b, input logic last,
                           input bit counted);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    byte_in <= b;
    string_end <= last;
    do @(posedge clk_i); while (in_stall);
    if (counted) items_sent++;
  endtask

  function automatic logic [utf8sd_pkg::ByteW-1:0] random_lead(input int unsigned len);
    case (len)
      1:       return {1'b0, 7'($urandom)};
      2:       return {3'b110, 5'($urandom)};
      3:       return {4'b1110, 4'($urandom)};
      default: return {5'b11110, 3'($urandom)};
    endcase
  endfunction

  function automatic logic [utf8sd_pkg::ByteW-1:0] random_cont();
    return {2'b10, 6'($urandom)};
  endfunction

  task automatic send_wellformed_string();
    int unsigned nchars;
    int unsigned len;
    nchars = $urandom_range(1, 6);
    for (int unsigned c = 0; c < nchars; c++) begin
      len = $urandom_range(1, 4);
      send_byte(random_lead(len), (c == nchars - 1) && (len == 1), 1'b1);
      for (int unsigned k = 1; k < len; k++) begin
        send_byte(random_cont(), (c == nchars - 1) && (k == len - 1), 1'b1);
      end
    end
  endtask

  task automatic send_broken_string();
    int unsigned len;
    int unsigned ndrop;
    case ($urandom_range(3))
      0: begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'($urandom), 1'b1);
      end
      1: begin
        len = $urandom_range(2, 4);
        send_byte(random_lead(len), 1'($urandom_range(3) == 0), 1'b1);
        for (int unsigned k = 1; k < $urandom_range(1, len - 1); k++) begin
          send_byte(random_cont(), 1'b0, 1'b1);
        end
        send_byte(random_cont(), 1'b1, 1'b1);
      end
      2: begin
        if ($urandom_range(1)) send_byte({2'b10, 6'($urandom)}, 1'($urandom), 1'b1);
        else send_byte({5'b11111, 3'($urandom)}, 1'($urandom), 1'b1);
        ndrop = $urandom_range(0, 3);
        repeat (ndrop) send_byte(8'($urandom), 1'b0, 1'b0);
        send_byte(8'($urandom), 1'b1, 1'b0);
      end
      default: begin
        send_byte(random_lead(2), 1'b0, 1'b1);
        send_byte(8'($urandom), 1'($urandom), 1'b1);
      end
    endcase
  endtask

  task automatic run_random_until(input int unsigned target);
    while (items_sent < target) begin
      if ($urandom_range(99) < 80) send_wellformed_string();
      else send_broken_string();
    end
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("utf8_stream_decoder verification failed");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed strings: ASCII extremes, each sequence length, the largest
    // code point, an unchecked continuation, invalid leads and truncation.
    send_byte(8'h00, 1'b0, 1'b1);
    send_byte(8'h7F, 1'b1, 1'b1);
    send_byte(8'hC2, 1'b0, 1'b1);
    send_byte(8'hA9, 1'b1, 1'b1);
    send_byte(8'hE2, 1'b0, 1'b1);
    send_byte(8'h82, 1'b0, 1'b1);
    send_byte(8'hAC, 1'b0, 1'b1);
    send_byte(8'hF7, 1'b0, 1'b1);
    send_byte(8'hBF, 1'b0, 1'b1);
    send_byte(8'hBF, 1'b0, 1'b1);
    send_byte(8'hBF, 1'b1, 1'b1);
    send_byte(8'hC3, 1'b0, 1'b1);
    send_byte(8'h41, 1'b1, 1'b1);
    send_byte(8'h80, 1'b0, 1'b1);
    send_byte(8'h41, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'hF8, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hE2, 1'b0, 1'b1);
    send_byte(8'h82, 1'b1, 1'b1);
    send_byte(8'hC3, 1'b1, 1'b1);
    send_byte(8'hF0, 1'b0, 1'b1);
    send_byte(8'h90, 1'b0, 1'b1);
    send_byte(8'h80, 1'b1, 1'b1);

    run_random_until(PhaseItems);
    tx_idle_pct = 51;
    rx_idle_pct = 11;
    run_random_until(2 * PhaseItems);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_request = 1'b1;
    run_random_until(3 * PhaseItems);
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (10) @(posedge clk_i);

    if (error_count == 0) begin
      $display("utf8_stream_decoder verification clean");
    end else begin
      $display("utf8_stream_decoder verification failed");
    end
    $finish;
  end

endmodule
